[sv/color_blob_tracker_defines.svh]
// Assertion macros for the color blob tracker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef COLOR_BLOB_TRACKER_DEFINES_SVH
`define COLOR_BLOB_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define CBT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("color blob tracker assertion failed");
`define CBT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("color blob tracker assertion failed");
`else
`define CBT_ASSERT_IMP(label, clk, rst, ante, cons)
`define CBT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/cbt_pkg.sv]
// Shared widths, codes and control types for the color blob tracker.
// No dependencies; imported by every module of the block.
package cbt_pkg;

   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;
   localparam int HIT_W      = 21;
   localparam int SUM_W      = 31;
   localparam int AREA_W     = 2 * POS_W;
   localparam int DENS_W     = 12;
   localparam int SEL_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam int REQ_DATA_W = 3 * PIX_W;
   localparam int RSP_FIELD_W = HIT_W + 6 * POS_W + DENS_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELD_W;

   localparam int POS_MAX_INT  = (1 << POS_W) - 1;
   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;
   localparam int DENS_SCALE   = 1000;

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [DENS_W-1:0] DENS_MAX = '1;

   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [CSR_ADDR_W-1:0] REG_LOWER0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_UPPER0 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LOWER1 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_UPPER1 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LOWER2 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_UPPER2 = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_CHSEL  = 3'd6;

   localparam logic [1:0] CHSEL_ALL = 2'd3;

   localparam logic [SEL_W-1:0] SEL_CX   = 2'd0;
   localparam logic [SEL_W-1:0] SEL_CY   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_DENS = 2'd2;

   typedef struct packed {
      logic             accept;
      logic             snap;
      logic             prod;
      logic             div_start;
      logic [SEL_W-1:0] div_sel;
      logic             div_store;
      logic             load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

[sv/color_blob_tracker.sv]
// Color blob tracker: pixels in raster order, one result per frame.
// Request channel: req_tdata = pix_ch0, pix_ch1, pix_ch2; req_tuser = row end;
// req_tlast = frame end. Result channel: rsp_tuser = bounds_ok; rsp_tdata =
// match count, box, centroid and fill density. The user must write registers
// through csr_we / csr_addr / csr_wdata only while no frame is in flight; the
// block itself does not enforce this. Within a frame req_tready stays high, so
// a frame streams at one pixel per clock. After the frame-end pixel, req_tready
// stays low while S_PROD forms the area and count products, the shared
// one-bit-per-cycle divider runs three divisions (column mean, row mean,
// density) and the result is loaded into the output register, which raises
// rsp_tvalid. If the receiver stalls, the result waits in the output register
// while the next frame streams in; at the end of that frame the block holds
// req_tready low until the output register can be reloaded.
// Synchronous reset clears the accumulators and the position counters, drops
// rsp_tvalid and restores the bounds to 0..255 with all channels tested.
module color_blob_tracker #(
   parameter int MAX_COLS = cbt_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = cbt_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cbt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cbt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pix_ch0 [7:0], pix_ch1 [15:8], pix_ch2 [23:16]
   input  logic [cbt_pkg::REQ_DATA_W-1:0] req_tdata,
   // row_end [0]
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // match_count [20:0], box_x_min [30:21], box_y_min [40:31],
   // box_x_max [50:41], box_y_max [60:51], center_x [70:61],
   // center_y [80:71], fill_density [92:81], zero [95:93]
   output logic [cbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bounds_ok [0]
   output logic                           rsp_tuser
);
   import cbt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbt_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/cbt_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cbt_pkg and the assertion macros in color_blob_tracker_defines.svh.
`include "color_blob_tracker_defines.svh"
module cbt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cbt_pkg::SUM_W-1:0] dividend,
   input  logic [cbt_pkg::HIT_W-1:0] divisor,
   output logic                      done,
   output logic [cbt_pkg::SUM_W-1:0] quotient
);
   import cbt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HIT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [HIT_W-1:0]     dvs_ff, dvs_in;
   logic [HIT_W:0]       trial;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = HIT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[HIT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `CBT_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

[sv/cbt_dp.sv]
// Datapath of the color blob tracker: bound registers, pixel test, frame
// accumulators, frame snapshot, products, divider and result register.
// Depends on cbt_pkg and cbt_div.
module cbt_dp #(
   parameter int MAX_COLS = cbt_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = cbt_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cbt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cbt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [cbt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  cbt_pkg::cmd_type               cmd,
   output cbt_pkg::sts_type               sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import cbt_pkg::*;

   localparam logic [POS_W-1:0] COL_LIMIT =
      POS_W'((MAX_COLS - 1 > POS_MAX_INT) ? POS_MAX_INT : MAX_COLS - 1);
   localparam logic [POS_W-1:0] ROW_LIMIT =
      POS_W'((MAX_ROWS - 1 > POS_MAX_INT) ? POS_MAX_INT : MAX_ROWS - 1);

   logic [PIX_W-1:0] lo_ff [3];
   logic [PIX_W-1:0] hi_ff [3];
   logic [1:0]       chsel_ff;

   logic [PIX_W-1:0] pix [3];
   logic [2:0]       ch_ok;
   logic             good;
   logic             bounds_ok;

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [HIT_W-1:0] hit_ff, hit_in;
   logic [POS_W-1:0] xmin_ff, xmin_in;
   logic [POS_W-1:0] ymin_ff, ymin_in;
   logic [POS_W-1:0] xmax_ff, xmax_in;
   logic [POS_W-1:0] ymax_ff, ymax_in;
   logic [SUM_W-1:0] sumc_ff, sumc_in;
   logic [SUM_W-1:0] sumr_ff, sumr_in;
   logic [SUM_W:0]   sumc_raw, sumr_raw;

   logic             snap_ok_ff;
   logic [HIT_W-1:0] snap_hit_ff;
   logic [POS_W-1:0] snap_xmin_ff, snap_ymin_ff, snap_xmax_ff, snap_ymax_ff;
   logic [SUM_W-1:0] snap_sumc_ff, snap_sumr_ff;

   logic [POS_W-1:0]  dx, dy;
   logic [AREA_W-1:0] area_ff;
   logic [SUM_W-1:0]  num_ff;

   logic [SUM_W-1:0]  div_dividend;
   logic [HIT_W-1:0]  div_divisor;
   logic              div_done;
   logic [SUM_W-1:0]  div_quo;

   logic [POS_W-1:0]  cx_ff, cy_ff;
   logic [DENS_W-1:0] dens_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   assign pix[0] = req_tdata[PIX_W-1:0];
   assign pix[1] = req_tdata[2*PIX_W-1:PIX_W];
   assign pix[2] = req_tdata[3*PIX_W-1:2*PIX_W];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch_ok[i] = (pix[i] >= lo_ff[i]) && (pix[i] <= hi_ff[i]);
      end
      good = (chsel_ff == CHSEL_ALL) ? (&ch_ok) : ch_ok[chsel_ff];
      bounds_ok = (lo_ff[0] <= hi_ff[0]) && (lo_ff[1] <= hi_ff[1]) &&
                  (lo_ff[2] <= hi_ff[2]);
   end

   always_comb begin
      sumc_raw = {1'b0, sumc_ff} + (SUM_W + 1)'(col_ff);
      sumr_raw = {1'b0, sumr_ff} + (SUM_W + 1)'(row_ff);
      hit_in  = hit_ff;
      xmin_in = xmin_ff;
      ymin_in = ymin_ff;
      xmax_in = xmax_ff;
      ymax_in = ymax_ff;
      sumc_in = sumc_ff;
      sumr_in = sumr_ff;
      if (good) begin
         hit_in  = (hit_ff == HIT_MAX) ? hit_ff : hit_ff + 1'b1;
         xmin_in = (col_ff < xmin_ff) ? col_ff : xmin_ff;
         ymin_in = (row_ff < ymin_ff) ? row_ff : ymin_ff;
         xmax_in = (col_ff > xmax_ff) ? col_ff : xmax_ff;
         ymax_in = (row_ff > ymax_ff) ? row_ff : ymax_ff;
         sumc_in = sumc_raw[SUM_W] ? SUM_MAX : sumc_raw[SUM_W-1:0];
         sumr_in = sumr_raw[SUM_W] ? SUM_MAX : sumr_raw[SUM_W-1:0];
      end
      col_in = col_ff;
      row_in = row_ff;
      if (req_tuser) begin
         col_in = '0;
         if (row_ff < ROW_LIMIT) begin
            row_in = row_ff + 1'b1;
         end
      end else if (col_ff < COL_LIMIT) begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '1;
         end
         chsel_ff <= CHSEL_ALL;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_LOWER0: lo_ff[0] <= csr_wdata;
            REG_UPPER0: hi_ff[0] <= csr_wdata;
            REG_LOWER1: lo_ff[1] <= csr_wdata;
            REG_UPPER1: hi_ff[1] <= csr_wdata;
            REG_LOWER2: lo_ff[2] <= csr_wdata;
            REG_UPPER2: hi_ff[2] <= csr_wdata;
            REG_CHSEL:  chsel_ff <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.snap) begin
         col_ff  <= '0;
         row_ff  <= '0;
         hit_ff  <= '0;
         xmin_ff <= POS_MAX;
         ymin_ff <= POS_MAX;
         xmax_ff <= '0;
         ymax_ff <= '0;
         sumc_ff <= '0;
         sumr_ff <= '0;
      end else if (cmd.accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         hit_ff  <= hit_in;
         xmin_ff <= xmin_in;
         ymin_ff <= ymin_in;
         xmax_ff <= xmax_in;
         ymax_ff <= ymax_in;
         sumc_ff <= sumc_in;
         sumr_ff <= sumr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         snap_ok_ff   <= bounds_ok;
         snap_hit_ff  <= hit_in;
         snap_xmin_ff <= xmin_in;
         snap_ymin_ff <= ymin_in;
         snap_xmax_ff <= xmax_in;
         snap_ymax_ff <= ymax_in;
         snap_sumc_ff <= sumc_in;
         snap_sumr_ff <= sumr_in;
      end
   end

   assign dx = (snap_xmax_ff >= snap_xmin_ff) ? snap_xmax_ff - snap_xmin_ff : '0;
   assign dy = (snap_ymax_ff >= snap_ymin_ff) ? snap_ymax_ff - snap_ymin_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         area_ff <= AREA_W'(dx) * AREA_W'(dy);
         num_ff  <= SUM_W'(snap_hit_ff) * SUM_W'(DENS_SCALE);
      end
   end

   always_comb begin
      case (cmd.div_sel)
         SEL_CX: begin
            div_dividend = snap_sumc_ff;
            div_divisor  = snap_hit_ff;
         end
         SEL_CY: begin
            div_dividend = snap_sumr_ff;
            div_divisor  = snap_hit_ff;
         end
         default: begin
            div_dividend = num_ff;
            div_divisor  = HIT_W'(area_ff);
         end
      endcase
   end

   cbt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_sel)
            SEL_CX: cx_ff <= (|div_quo[SUM_W-1:POS_W]) ? POS_MAX : div_quo[POS_W-1:0];
            SEL_CY: cy_ff <= (|div_quo[SUM_W-1:POS_W]) ? POS_MAX : div_quo[POS_W-1:0];
            default: begin
               dens_ff <= (|div_quo[SUM_W-1:DENS_W]) ? DENS_MAX : div_quo[DENS_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_user_ff <= snap_ok_ff;
         if (snap_ok_ff) begin
            rsp_data_ff <= {
               {RSP_PAD_W{1'b0}},
               ((snap_hit_ff != '0) && (area_ff != '0)) ? dens_ff : {DENS_W{1'b0}},
               (snap_hit_ff != '0) ? cy_ff : {POS_W{1'b0}},
               (snap_hit_ff != '0) ? cx_ff : {POS_W{1'b0}},
               snap_ymax_ff, snap_xmax_ff, snap_ymin_ff, snap_xmin_ff, snap_hit_ff
            };
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser    = rsp_user_ff;

endmodule

[sv/cbt_ctrl.sv]
// Controller of the color blob tracker: pixel acceptance and the frame-end
// sequence of products, three divisions and result load. Depends on cbt_pkg.
`include "color_blob_tracker_defines.svh"
module cbt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   input  cbt_pkg::sts_type sts,
   output cbt_pkg::cmd_type cmd
);
   import cbt_pkg::*;

   localparam logic [2:0] S_ACCUM     = 3'd0;
   localparam logic [2:0] S_PROD      = 3'd1;
   localparam logic [2:0] S_DIV_START = 3'd2;
   localparam logic [2:0] S_DIV_WAIT  = 3'd3;
   localparam logic [2:0] S_OUT       = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic             accept;

   assign req_tready = (state_ff == S_ACCUM);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         S_ACCUM: begin
            if (accept && req_tlast) begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            sel_in   = SEL_CX;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               if (sel_ff == SEL_DENS) begin
                  state_in = S_OUT;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               state_in = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCUM;
         sel_ff   <= SEL_CX;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign cmd.accept    = accept;
   assign cmd.snap      = accept && req_tlast;
   assign cmd.prod      = (state_ff == S_PROD);
   assign cmd.div_start = (state_ff == S_DIV_START);
   assign cmd.div_sel   = sel_ff;
   assign cmd.div_store = (state_ff == S_DIV_WAIT) && sts.div_done;
   assign cmd.load_out  = (state_ff == S_OUT) && sts.out_free;

   `CBT_ASSERT_NXT(a_frame_end_stalls, clock, reset, accept && req_tlast, !req_tready)
   `CBT_ASSERT_IMP(a_done_in_wait, clock, reset, sts.div_done, state_ff == S_DIV_WAIT)
   `CBT_ASSERT_NXT(a_out_held, clock, reset, (state_ff == S_OUT) && !sts.out_free, state_ff == S_OUT)

endmodule

[bench/tb_color_blob_tracker.sv]
// Self-checking testbench for color_blob_tracker: streams pixel frames through the request
// channel under changing bounds and compares each frame result with a built-in tracker model
// or a fixed probe report. Depends on cbt_pkg and the color_blob_tracker RTL only.
`timescale 1ns / 1ps

module tb_color_blob_tracker;
   import cbt_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 500;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int WIDE_ROW_LEN  = 1030;
   localparam int TALL_ROWS     = 1030;
   localparam int unsigned CYCLE_LIMIT = 4000000;

   localparam int COL_LIMIT =
      (DEF_MAX_COLS - 1 > POS_MAX_INT) ? POS_MAX_INT : DEF_MAX_COLS - 1;
   localparam int ROW_LIMIT =
      (DEF_MAX_ROWS - 1 > POS_MAX_INT) ? POS_MAX_INT : DEF_MAX_ROWS - 1;
   localparam longint HIT_LIMIT  = (longint'(1) << HIT_W) - 1;
   localparam longint SUM_LIMIT  = (longint'(1) << SUM_W) - 1;
   localparam longint DENS_LIMIT = (longint'(1) << DENS_W) - 1;

   typedef struct packed {
      logic [2:0][PIX_W-1:0] ch;
      logic                  row_end;
      logic                  frame_end;
   } pixel_t;

   typedef struct packed {
      logic [DENS_W-1:0] fill_density;
      logic [POS_W-1:0]  center_y;
      logic [POS_W-1:0]  center_x;
      logic [POS_W-1:0]  box_y_max;
      logic [POS_W-1:0]  box_x_max;
      logic [POS_W-1:0]  box_y_min;
      logic [POS_W-1:0]  box_x_min;
      logic [HIT_W-1:0]  match_count;
   } blob_stats_t;

   typedef struct packed {
      logic        bounds_ok;
      blob_stats_t stats;
   } blob_report_t;

   typedef struct packed {
      logic [2:0][PIX_W-1:0] lo;
      logic [2:0][PIX_W-1:0] hi;
      logic [SEL_W-1:0]      sel;
   } blob_setting_t;

   typedef struct {
      pixel_t       pix;
      int           setting;
      bit           typed;
      blob_report_t want;
   } probe_row_t;

   localparam blob_report_t BAD_BOUNDS_REPORT = '0;
   localparam blob_report_t SOLO_REPORT = '{bounds_ok: 1'b1, stats: '{
      fill_density: '0, center_y: '0, center_x: '0, box_y_max: '0, box_x_max: '0,
      box_y_min: '0, box_x_min: '0, match_count: 21'd1}};
   localparam blob_report_t SQUARE_REPORT = '{bounds_ok: 1'b1, stats: '{
      fill_density: 12'd4000, center_y: '0, center_x: '0, box_y_max: 10'd1,
      box_x_max: 10'd1, box_y_min: '0, box_x_min: '0, match_count: 21'd4}};
   localparam blob_report_t EMPTY_REPORT = '{bounds_ok: 1'b1, stats: '{
      fill_density: '0, center_y: '0, center_x: '0, box_y_max: '0, box_x_max: '0,
      box_y_min: POS_MAX, box_x_min: POS_MAX, match_count: '0}};

   localparam blob_setting_t RESET_SETTING =
      '{lo: 24'h000000, hi: 24'hFFFFFF, sel: CHSEL_ALL};
   localparam blob_setting_t WIDE_ROW_SETTING =
      '{lo: 24'h000080, hi: 24'hFFFFFF, sel: 2'd0};

   blob_setting_t probe_settings [7] = '{
      RESET_SETTING,
      '{lo: 24'h0000C8, hi: 24'hFFFF64, sel: CHSEL_ALL},
      '{lo: 24'h000064, hi: 24'hFFFFC8, sel: 2'd0},
      '{lo: 24'h000000, hi: 24'hFF00FF, sel: 2'd1},
      '{lo: 24'hFF0000, hi: 24'hFFFFFF, sel: 2'd2},
      '{lo: 24'h0A0A0A, hi: 24'h141414, sel: CHSEL_ALL},
      '{lo: 24'h010000, hi: 24'h00FFFF, sel: 2'd0}
   };

   probe_row_t probe_rows [18] = '{
      '{{24'h000000, 1'b1, 1'b1}, 0, 1'b1, SOLO_REPORT},
      '{{24'hFFFFFF, 1'b0, 1'b0}, 0, 1'b0, '0},
      '{{24'h000000, 1'b1, 1'b0}, 0, 1'b0, '0},
      '{{24'hFF00FF, 1'b0, 1'b0}, 0, 1'b0, '0},
      '{{24'h00FF00, 1'b0, 1'b1}, 0, 1'b1, SQUARE_REPORT},
      '{{24'h123456, 1'b0, 1'b0}, 1, 1'b0, '0},
      '{{24'hABCDEF, 1'b0, 1'b1}, 1, 1'b1, BAD_BOUNDS_REPORT},
      '{{24'h00FF63, 1'b0, 1'b0}, 2, 1'b0, '0},
      '{{24'hFF0064, 1'b1, 1'b0}, 2, 1'b0, '0},
      '{{24'h5A5AC8, 1'b0, 1'b0}, 2, 1'b0, '0},
      '{{24'hA5A5C9, 1'b0, 1'b1}, 2, 1'b0, '0},
      '{{24'h550055, 1'b1, 1'b0}, 3, 1'b0, '0},
      '{{24'h000100, 1'b0, 1'b1}, 3, 1'b0, '0},
      '{{24'hFEFFFF, 1'b0, 1'b0}, 4, 1'b0, '0},
      '{{24'hFF0000, 1'b0, 1'b1}, 4, 1'b0, '0},
      '{{24'h0A0A09, 1'b0, 1'b0}, 5, 1'b0, '0},
      '{{24'h150A0A, 1'b1, 1'b1}, 5, 1'b1, EMPTY_REPORT},
      '{{24'h777777, 1'b0, 1'b1}, 6, 1'b1, BAD_BOUNDS_REPORT}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   blob_setting_t active_cfg = RESET_SETTING;
   int     col_pos = 0;
   int     row_pos = 0;
   int     x_lo = POS_MAX_INT;
   int     y_lo = POS_MAX_INT;
   int     x_hi = 0;
   int     y_hi = 0;
   longint hits = 0;
   longint col_sum = 0;
   longint row_sum = 0;

   blob_report_t pending_reports [$];
   int          fail_count = 0;
   int          random_sent = 0;
   int          gap_odds = 4;
   bit          steady = 1'b0;
   bit          hold_rsp = 1'b0;
   int unsigned cycle_count = 0;

   color_blob_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit in_bounds(int k, logic [PIX_W-1:0] v);
      return v >= active_cfg.lo[k] && v <= active_cfg.hi[k];
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      hits = 0;
      x_lo = POS_MAX_INT;
      y_lo = POS_MAX_INT;
      x_hi = 0;
      y_hi = 0;
      col_sum = 0;
      row_sum = 0;
   endtask

   task automatic track_pixel(input pixel_t p, output bit done, output blob_report_t rep);
      bit     hit;
      longint area;
      longint quot;
      done = 1'b0;
      rep = '0;
      if (active_cfg.sel == CHSEL_ALL)
         hit = in_bounds(0, p.ch[0]) && in_bounds(1, p.ch[1]) && in_bounds(2, p.ch[2]);
      else
         hit = in_bounds(active_cfg.sel, p.ch[active_cfg.sel]);
      if (hit) begin
         hits = (hits < HIT_LIMIT) ? hits + 1 : HIT_LIMIT;
         if (col_pos < x_lo) x_lo = col_pos;
         if (row_pos < y_lo) y_lo = row_pos;
         if (col_pos > x_hi) x_hi = col_pos;
         if (row_pos > y_hi) y_hi = row_pos;
         col_sum = (col_sum + col_pos > SUM_LIMIT) ? SUM_LIMIT : col_sum + col_pos;
         row_sum = (row_sum + row_pos > SUM_LIMIT) ? SUM_LIMIT : row_sum + row_pos;
      end
      if (!p.frame_end) begin
         if (p.row_end) begin
            col_pos = 0;
            if (row_pos < ROW_LIMIT) row_pos++;
         end else if (col_pos < COL_LIMIT) begin
            col_pos++;
         end
         return;
      end
      done = 1'b1;
      if (active_cfg.lo[0] <= active_cfg.hi[0] && active_cfg.lo[1] <= active_cfg.hi[1] &&
          active_cfg.lo[2] <= active_cfg.hi[2]) begin
         rep.bounds_ok = 1'b1;
         rep.stats.match_count = HIT_W'(hits);
         rep.stats.box_x_min = POS_W'(x_lo);
         rep.stats.box_y_min = POS_W'(y_lo);
         rep.stats.box_x_max = POS_W'(x_hi);
         rep.stats.box_y_max = POS_W'(y_hi);
         if (hits > 0) begin
            quot = col_sum / hits;
            rep.stats.center_x = POS_W'((quot > POS_MAX_INT) ? POS_MAX_INT : quot);
            quot = row_sum / hits;
            rep.stats.center_y = POS_W'((quot > POS_MAX_INT) ? POS_MAX_INT : quot);
            area = longint'(x_hi - x_lo) * longint'(y_hi - y_lo);
            if (area > 0) begin
               quot = (hits * DENS_SCALE) / area;
               rep.stats.fill_density = DENS_W'((quot > DENS_LIMIT) ? DENS_LIMIT : quot);
            end
         end
      end
      restart_frame();
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input blob_setting_t s);
      write_reg(REG_LOWER0, s.lo[0]);
      write_reg(REG_UPPER0, s.hi[0]);
      write_reg(REG_LOWER1, s.lo[1]);
      write_reg(REG_UPPER1, s.hi[1]);
      write_reg(REG_LOWER2, s.lo[2]);
      write_reg(REG_UPPER2, s.hi[2]);
      write_reg(REG_CHSEL, CSR_DATA_W'(s.sel));
      csr_we <= 1'b0;
      active_cfg = s;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixel(input pixel_t p, input bit use_typed = 1'b0,
                             input blob_report_t typed_rep = '0);
      bit           done;
      blob_report_t rep;
      req_tvalid <= 1'b1;
      req_tdata <= p.ch;
      req_tuser <= p.row_end;
      req_tlast <= p.frame_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_pixel(p, done, rep);
      if (done) pending_reports.push_back(use_typed ? typed_rep : rep);
      if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   function automatic logic [PIX_W-1:0] pick_level(int k);
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      lo = active_cfg.lo[k];
      hi = active_cfg.hi[k];
      case ($urandom_range(0, 4))
         0: return lo - PIX_W'($urandom_range(0, 1));
         1: return hi + PIX_W'($urandom_range(0, 1));
         2, 3: return (lo <= hi) ? lo + PIX_W'($urandom_range(0, hi - lo))
                                 : PIX_W'($urandom_range(0, 255));
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic blob_setting_t pick_setting();
      blob_setting_t    s;
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      for (int k = 0; k < 3; k++) begin
         a = PIX_W'($urandom_range(0, 255));
         b = PIX_W'($urandom_range(0, 255));
         case ($urandom_range(0, 29))
            0: begin
               s.lo[k] = (a > b) ? a : b;
               s.hi[k] = (a > b) ? b : a;
            end
            1, 2, 3, 4, 5, 6, 7: begin
               s.lo[k] = '0;
               s.hi[k] = '1;
            end
            8, 9: begin
               s.lo[k] = a;
               s.hi[k] = a;
            end
            default: begin
               s.lo[k] = (a > b) ? b : a;
               s.hi[k] = (a > b) ? a : b;
            end
         endcase
      end
      s.sel = SEL_W'($urandom_range(0, 3));
      return s;
   endfunction

   task automatic send_frame();
      int     cols;
      int     rows;
      int     pick;
      bit     ragged;
      pixel_t p;
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
         cols = $urandom_range(64, 100);
         rows = $urandom_range(2, 4);
      end else if (pick < 5) begin
         cols = $urandom_range(1, 40);
         rows = $urandom_range(1, 12);
      end else begin
         cols = $urandom_range(1, 8);
         rows = $urandom_range(1, 6);
      end
      ragged = ($urandom_range(0, 9) == 0);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            p.ch[0] = pick_level(0);
            p.ch[1] = pick_level(1);
            p.ch[2] = pick_level(2);
            p.frame_end = (r == rows - 1) && (c == cols - 1);
            if (ragged)
               p.row_end = ($urandom_range(0, 3) == 0);
            else if (p.frame_end)
               p.row_end = $urandom_range(0, 1);
            else
               p.row_end = (c == cols - 1);
            push_pixel(p);
            random_sent++;
         end
      end
   endtask

   // Rows longer than the column counter can reach; only the last columns match,
   // which also drives the fill density past its ceiling.
   task automatic send_wide_rows();
      pixel_t p;
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < WIDE_ROW_LEN; c++) begin
            p.ch[0] = (c >= 1022) ? PIX_W'($urandom_range(128, 255))
                                  : PIX_W'($urandom_range(0, 127));
            p.ch[1] = PIX_W'($urandom_range(0, 255));
            p.ch[2] = PIX_W'($urandom_range(0, 255));
            p.row_end = (c == WIDE_ROW_LEN - 1);
            p.frame_end = (r == 1) && (c == WIDE_ROW_LEN - 1);
            push_pixel(p);
         end
      end
   endtask

   task automatic send_tall_column();
      pixel_t p;
      for (int r = 0; r < TALL_ROWS; r++) begin
         p.ch[0] = PIX_W'($urandom_range(0, 255));
         p.ch[1] = PIX_W'($urandom_range(0, 255));
         p.ch[2] = PIX_W'($urandom_range(0, 255));
         p.row_end = 1'b1;
         p.frame_end = (r == TALL_ROWS - 1);
         push_pixel(p);
      end
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      blob_report_t want;
      blob_stats_t  got;
      if (rsp_tvalid && rsp_tready) begin
         got = blob_stats_t'(rsp_tdata[RSP_FIELD_W-1:0]);
         if (pending_reports.size() == 0) begin
            $error("frame result arrived with no frame pending");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("bounds_ok", want.bounds_ok, rsp_tuser);
            check_field("match_count", want.stats.match_count, got.match_count);
            check_field("box_x_min", want.stats.box_x_min, got.box_x_min);
            check_field("box_y_min", want.stats.box_y_min, got.box_y_min);
            check_field("box_x_max", want.stats.box_x_max, got.box_x_max);
            check_field("box_y_max", want.stats.box_y_max, got.box_y_max);
            check_field("center_x", want.stats.center_x, got.center_x);
            check_field("center_y", want.stats.center_y, got.center_y);
            check_field("fill_density", want.stats.fill_density, got.fill_density);
         end
      end
   end

   initial begin : result_sink
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : pixel_source
      int current_setting;
      int phase;
      current_setting = 0;
      phase = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_rows[i]) begin
         if (probe_rows[i].setting != current_setting) begin
            drain_results();
            apply_setting(probe_settings[probe_rows[i].setting]);
            current_setting = probe_rows[i].setting;
         end
         push_pixel(probe_rows[i].pix, probe_rows[i].typed, probe_rows[i].want);
      end

      while (random_sent < RANDOM_ITEMS) begin
         drain_results();
         if (phase == 2) begin
            apply_setting(WIDE_ROW_SETTING);
            send_wide_rows();
            drain_results();
         end
         if (phase == 4) begin
            apply_setting(RESET_SETTING);
            send_tall_column();
            drain_results();
         end
         apply_setting(pick_setting());
         steady = (RANDOM_ITEMS - random_sent < 200);
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 8;
         endcase
         if (phase == 1) hold_rsp = 1'b1;
         repeat (6) send_frame();
         phase++;
      end

      drain_results();
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
